// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/tdpb_pkg.sv =====
`default_nettype none
package tdpb_pkg;

   localparam int DEPTH_DEF  = 1024;
   localparam int TIME_W     = 32;
   localparam int SVC_W      = 16;
   localparam int CAP_W      = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // register index, taken from the word address bit of the csr port
   localparam logic REG_CAPACITY = 1'b0;

endpackage
`default_nettype wire

// ===== hw/rtl/tdpb_csr.sv =====
`default_nettype none
module tdpb_csr
   import tdpb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [CAP_W-1:0]      capacity
);

   logic [CAP_W-1:0] cap_ff;
   logic             reg_sel;

   assign pready   = 1'b1;
   assign reg_sel  = (paddr[2] == REG_CAPACITY);
   assign capacity = cap_ff;
   assign prdata   = reg_sel ? CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tdpb_ring.sv =====
`default_nettype none
module tdpb_ring #(
   parameter int DEPTH  = 1024,
   parameter int IDX_W  = 10,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tdpb_ctrl.sv =====
`default_nettype none
module tdpb_ctrl
   import tdpb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int IDX_W = 10,
   parameter int CNT_W = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TIME_W-1:0] req_arrival_time,
   input  wire logic [SVC_W-1:0]  req_service_time,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_dropped,
   output logic      [TIME_W-1:0] rsp_start_time,
   input  wire logic [CAP_W-1:0]  capacity,
   output logic      [IDX_W-1:0]  mem_rd_addr,
   input  wire logic [TIME_W-1:0] mem_rd_data,
   output logic                   mem_wr_en,
   output logic      [IDX_W-1:0]  mem_wr_addr,
   output logic      [TIME_W-1:0] mem_wr_data
);

   typedef enum logic {IDLE, CHECK} state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  head_ff;
   logic [IDX_W-1:0]  tail_ff;
   logic [CNT_W-1:0]  occ_ff;
   logic [TIME_W-1:0] last_ff;
   logic [TIME_W-1:0] arr_ff;
   logic [SVC_W-1:0]  svc_ff;
   logic              rsp_valid_ff;
   logic              rsp_dropped_ff;
   logic [TIME_W-1:0] rsp_start_ff;

   logic              rsp_free;
   logic              occ_nz;
   logic              pop;
   logic              full;
   logic              finish;
   logic [IDX_W-1:0]  head_inc;
   logic [IDX_W-1:0]  tail_inc;
   logic [TIME_W-1:0] start;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] fin;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign occ_nz   = (occ_ff != '0);
   assign pop      = (state_ff == CHECK) && occ_nz && (mem_rd_data <= arr_ff);
   assign full     = (32'(occ_ff) >= 32'(capacity)) || (32'(occ_ff) >= 32'(DEPTH));
   assign finish   = (state_ff == CHECK) && !pop && rsp_free;

   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   assign start = occ_nz ? last_ff : arr_ff;
   assign sum   = {1'b0, start} + (TIME_W+1)'(svc_ff);
   assign fin   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

   // read ahead at the new head while popping
   assign mem_rd_addr = pop ? head_inc : head_ff;
   assign mem_wr_en   = finish && !full;
   assign mem_wr_addr = tail_ff;
   assign mem_wr_data = fin;

   assign req_stall      = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_start_time = rsp_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  arr_ff   <= req_arrival_time;
                  svc_ff   <= req_service_time;
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               if (pop) begin
                  head_ff <= head_inc;
                  occ_ff  <= occ_ff - 1'b1;
               end else if (finish) begin
                  rsp_dropped_ff <= full;
                  rsp_start_ff   <= full ? '0 : start;
                  if (!full) begin
                     tail_ff <= tail_inc;
                     occ_ff  <= occ_ff + 1'b1;
                     last_ff <= fin;
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tail_drop_packet_buffer_sim.sv =====
// Tail-drop packet buffer in front of one in-order server.
// Input channel req_*: one item per packet (arrival tick, service ticks),
// valid/stall handshake. Result channel rsp_*: one item per input item,
// dropped flag and start tick (zero when dropped), in input order.
// Config port csr_*: APB-style, buffer_capacity at byte address 0,
// always ready, readable.
// Sequence: after an item is accepted, the queued finish times that expire
// at its arrival are popped, then the item's result is registered.
// The ring memory has one read port and a registered read, so expired
// entries are popped one at a time. A new item is taken only once the
// previous one has produced its result.
// Reset: queue empties, capacity returns to 1024, output valid clears.
// Ring contents are not cleared; only entries written since are read.
// Receiver stall: the result holds in the output register; the next item
// is still accepted and processed up to its result, which then waits until
// the output register is taken.
`default_nettype none
module tail_drop_packet_buffer_sim
   import tdpb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [TIME_W-1:0]     req_arrival_time,
   input  wire logic [SVC_W-1:0]      req_service_time,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_dropped,
   output logic      [TIME_W-1:0]     rsp_start_time,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CAP_W-1:0]  capacity;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [TIME_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [TIME_W-1:0] mem_wr_data;

   tdpb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .capacity (capacity)
   );

   tdpb_ring #(
      .DEPTH  (DEPTH),
      .IDX_W  (IDX_W),
      .DATA_W (TIME_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tdpb_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_arrival_time (req_arrival_time),
      .req_service_time (req_service_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dropped      (rsp_dropped),
      .rsp_start_time   (rsp_start_time),
      .capacity         (capacity),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/tdpb_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module tdpb_checker
   import tdpb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_dropped,
   input wire logic [TIME_W-1:0] rsp_start_time
);

   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_dropped) && $stable(rsp_start_time))
   `ASSERT_IMP(a_drop_zero_start, clock, reset, rsp_valid && rsp_dropped, rsp_start_time == '0)
   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind tail_drop_packet_buffer_sim tdpb_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_dropped    (rsp_dropped),
   .rsp_start_time (rsp_start_time)
);
`default_nettype wire
